// File: rtl/core/sack_reorder_receiver_macros.svh
// ---------------------------------------------------------------------------
// SACK reorder receiver assertion macros
// Shared assertion forms used by the receiver modules. They assume a clock
// named clock and a synchronous active-high reset named reset.
// ---------------------------------------------------------------------------
`ifndef SACK_REORDER_RECEIVER_MACROS_SVH
`define SACK_REORDER_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/srr_pkg.sv
// ---------------------------------------------------------------------------
// SACK reorder receiver package
// Window geometry, field widths, shared types and result codes.
// ---------------------------------------------------------------------------
package srr_pkg;

   localparam int WINDOW        = 32;
   localparam int SLOT_BITS     = $clog2(WINDOW);
   localparam int NUM_WIDTH     = 31;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int HISTORY_BITS  = 32;

   typedef logic [SLOT_BITS-1:0]     slot_type;
   typedef logic [NUM_WIDTH-1:0]     num_type;
   typedef logic [PAYLOAD_WIDTH-1:0] payload_type;
   typedef logic [HISTORY_BITS-1:0]  history_type;
   typedef logic [WINDOW-1:0]        window_type;

   localparam num_type NUM_MAX = '1;

   localparam logic KIND_DELIVERY = 1'b0;
   localparam logic KIND_REPORT   = 1'b1;

   typedef struct packed {
      num_type     latest_ack;
      history_type ack_history;
      num_type     first_nack;
   } report_type;

endpackage

// File: rtl/core/sack_reorder_receiver.sv
// ---------------------------------------------------------------------------
// SACK reorder receiver
// Receive side of a selective-repeat link with a reorder window and a
// SACK-style ack history report at the end of each packet.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one received message (or an empty packet marker)
//   per item. The rsp_ channel returns delivered messages in order and, at
//   the end of each packet, one ack report item with rsp_last set.
//   An item without end_of_packet is taken and gives no result.
//   An end-of-packet item then checks the next in-order slot: each delivered
//   message takes a valid-bit check (ST_CHECK), then a payload RAM read
//   (ST_FETCH); the final check is followed by the window scan (ST_SCAN)
//   and the report stage (ST_REPORT), which loads the report. The registered
//   read of the payload RAM is why each delivery needs its own fetch state.
//   req_stall is high while a packet end is being worked off; a new item is
//   taken while the last report still waits in the output register.
//   While rsp_stall is high an item in the output register stays there and
//   the delivery walk pauses. Reset empties the window, clears the in-order
//   number and the packet flags; payload RAM contents are left as they are.
// ---------------------------------------------------------------------------
`include "sack_reorder_receiver_macros.svh"

module sack_reorder_receiver import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_has_message,
   input  num_type     req_order_number,
   input  payload_type req_payload,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output num_type     rsp_delivered_number,
   output payload_type rsp_delivered_payload,
   output num_type     rsp_latest_ack,
   output history_type rsp_ack_history,
   output num_type     rsp_first_nack,
   output logic        rsp_ack_changed,
   output logic        rsp_window_overflow,
   output logic        rsp_last
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   logic [2:0]  state_ff, state_in;
   num_type     io_ff, io_in;
   window_type  valid_ff, valid_in;
   logic        changed_ff, changed_in;
   logic        overflow_ff, overflow_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   num_type     out_number_ff, out_number_in;
   payload_type out_payload_ff, out_payload_in;
   report_type  out_report_ff, out_report_in;
   logic        out_changed_ff, out_changed_in;
   logic        out_overflow_ff, out_overflow_in;

   logic        req_fire;
   logic        out_free;
   num_type     io_next;
   slot_type    next_slot;
   num_type     offset;
   logic        above;
   logic        in_window;
   slot_type    wr_slot;
   logic        store;
   logic        load_delivery;
   logic        load_report;
   payload_type rd_payload;
   report_type  scan_report;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign io_next   = io_ff + num_type'(1);
   assign next_slot = slot_type'(io_next);

   assign above     = req_order_number > io_ff;
   assign offset    = req_order_number - io_ff - num_type'(1);
   assign in_window = above && (offset[NUM_WIDTH-1:SLOT_BITS] == '0);
   assign wr_slot   = slot_type'(req_order_number);
   assign store     = req_fire && req_has_message && in_window && !valid_ff[wr_slot];

   assign load_delivery = (state_ff == ST_FETCH) && out_free;
   assign load_report   = (state_ff == ST_REPORT) && out_free;

   srr_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (WINDOW)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (wr_slot),
      .wr_data (req_payload),
      .rd_addr (next_slot),
      .rd_data (rd_payload)
   );

   srr_scan u_scan (
      .clock     (clock),
      .start     (state_ff == ST_SCAN),
      .valid_vec (valid_ff),
      .in_order  (io_ff),
      .report    (scan_report)
   );

   always_comb begin
      state_in    = state_ff;
      io_in       = io_ff;
      valid_in    = valid_ff;
      changed_in  = changed_ff;
      overflow_in = overflow_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (store) begin
                  valid_in[wr_slot] = 1'b1;
                  changed_in        = 1'b1;
               end
               if (req_has_message && above && !in_window) begin
                  overflow_in = 1'b1;
               end
               if (req_end_of_packet) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // The RAM read of the next slot is issued at the end of this cycle.
            if (valid_ff[next_slot] && (io_ff != NUM_MAX)) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FETCH: begin
            if (load_delivery) begin
               valid_in[next_slot] = 1'b0;
               io_in               = io_next;
               state_in            = ST_CHECK;
            end
         end
         ST_SCAN: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (load_report) begin
               changed_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in    = out_valid_ff && rsp_stall;
      out_kind_in     = out_kind_ff;
      out_number_in   = out_number_ff;
      out_payload_in  = out_payload_ff;
      out_report_in   = out_report_ff;
      out_changed_in  = out_changed_ff;
      out_overflow_in = out_overflow_ff;
      priority if (load_delivery) begin
         out_valid_in    = 1'b1;
         out_kind_in     = KIND_DELIVERY;
         out_number_in   = io_next;
         out_payload_in  = rd_payload;
         out_report_in   = '0;
         out_changed_in  = 1'b0;
         out_overflow_in = 1'b0;
      end else if (load_report) begin
         out_valid_in    = 1'b1;
         out_kind_in     = KIND_REPORT;
         out_number_in   = '0;
         out_payload_in  = '0;
         out_report_in   = scan_report;
         out_changed_in  = changed_ff;
         out_overflow_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         io_ff        <= '0;
         valid_ff     <= '0;
         changed_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         io_ff        <= io_in;
         valid_ff     <= valid_in;
         changed_ff   <= changed_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff     <= out_kind_in;
      out_number_ff   <= out_number_in;
      out_payload_ff  <= out_payload_in;
      out_report_ff   <= out_report_in;
      out_changed_ff  <= out_changed_in;
      out_overflow_ff <= out_overflow_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_kind              = out_kind_ff;
   assign rsp_delivered_number  = out_number_ff;
   assign rsp_delivered_payload = out_payload_ff;
   assign rsp_latest_ack        = out_report_ff.latest_ack;
   assign rsp_ack_history       = out_report_ff.ack_history;
   assign rsp_first_nack        = out_report_ff.first_nack;
   assign rsp_ack_changed       = out_changed_ff;
   assign rsp_window_overflow   = out_overflow_ff;
   assign rsp_last              = (out_kind_ff == KIND_REPORT);

   `SRR_ASSERT_NOW(a_fetch_slot_held, (state_ff == ST_FETCH), valid_ff[next_slot], "empty fetch")
   `SRR_ASSERT_NOW(a_fetch_below_top, (state_ff == ST_FETCH), (io_ff != NUM_MAX), "fetch at top")
   `SRR_ASSERT_NEXT(a_delivery_advances, load_delivery, (io_ff == $past(io_next)), "no advance")
   `SRR_ASSERT_NEXT(a_report_clears_flags, load_report, (!changed_ff && !overflow_ff), "flags kept")

endmodule

// File: rtl/core/srr_ram.sv
// ---------------------------------------------------------------------------
// SACK reorder receiver generic RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module srr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/srr_scan.sv
// ---------------------------------------------------------------------------
// SACK reorder receiver window scan
// Finds the lowest and highest held numbers of the window and forms the
// ack report in the cycle after start.
// ---------------------------------------------------------------------------
module srr_scan import srr_pkg::*; (
   input  logic       clock,
   input  logic       start,
   input  window_type valid_vec,
   input  num_type    in_order,
   output report_type report
);

   window_type rot_in;
   logic       any_in;
   slot_type   lo_in;
   slot_type   hi_in;

   logic       any_ff;
   slot_type   lo_ff;
   slot_type   hi_ff;
   window_type rot_ff;
   num_type    io_ff;

   // Stage one: align the window so that bit k is number in_order + 1 + k.
   always_comb begin
      slot_type base;
      slot_type idx;
      base = slot_type'(in_order + num_type'(1));
      lo_in = '0;
      hi_in = '0;
      for (int k = 0; k < WINDOW; k++) begin
         idx = base + slot_type'(k);
         rot_in[k] = valid_vec[idx];
      end
      for (int k = WINDOW - 1; k >= 0; k--) begin
         if (rot_in[k]) begin
            lo_in = slot_type'(k);
         end
      end
      for (int k = 0; k < WINDOW; k++) begin
         if (rot_in[k]) begin
            hi_in = slot_type'(k);
         end
      end
      any_in = |rot_in;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         any_ff <= any_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         rot_ff <= rot_in;
         io_ff  <= in_order;
      end
   end

   // Stage two: history bit b covers number highest - 1 - b. Bits at or
   // below the in-order point read as ones, the rest come from the window.
   always_comb begin
      window_type                           rev;
      logic [HISTORY_BITS+WINDOW-1:0]       ext;
      logic [HISTORY_BITS+WINDOW-1:0]       shifted;
      logic [SLOT_BITS:0]                   shamt;
      for (int k = 0; k < WINDOW; k++) begin
         rev[WINDOW-1-k] = rot_ff[k];
      end
      ext     = {{HISTORY_BITS{1'b1}}, rev};
      shamt   = (SLOT_BITS+1)'(WINDOW) - {1'b0, hi_ff};
      shifted = ext >> shamt;
      if (any_ff) begin
         report.latest_ack  = io_ff + num_type'(hi_ff) + num_type'(1);
         report.ack_history = shifted[HISTORY_BITS-1:0];
         report.first_nack  = io_ff + num_type'(lo_ff);
      end else begin
         report.latest_ack  = io_ff;
         report.ack_history = '1;
         report.first_nack  = '0;
      end
   end

endmodule
